/* rtl/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants for the weight stability detector
// ----------------------------------------------------------------------------
package wsd_pkg;

    // input command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_START  = 1'b1;

    // result status codes
    localparam logic STATUS_STABLE  = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_BLOCK = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPREAD        = 1'b1;

    // register and field widths
    localparam int SPB_W      = 8;
    localparam int SPREAD_W   = 23;
    localparam int CFG_DATA_W = 23;
    localparam int BLOCKS_W   = 5;

    // register reset values
    localparam logic [SPB_W-1:0]    SPB_RESET    = 8'd10;
    localparam logic [SPREAD_W-1:0] SPREAD_RESET = 23'd200;

    // control from the sequencer to the window ring
    typedef struct packed {
        logic clear;
        logic wr_en;
    } win_ctrl_t;

endpackage

/* rtl/wsd_div.sv */
// ----------------------------------------------------------------------------
// wsd_div
// iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncates toward zero
// ----------------------------------------------------------------------------
module wsd_div #(
    parameter int DVD_W  = 32,
    parameter int DVS_W  = 8,
    parameter int QUOT_W = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DVD_W-1:0]  dividend,
    input  logic        [DVS_W-1:0]  divisor,
    output logic                     done,
    output logic signed [QUOT_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DVD_W-1:0] mag_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;
    logic [DVD_W-1:0] signed_quot;

    // shared subtract and compare
    assign trial = {rem_reg, mag_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DVD_W-1];
            mag_reg <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            mag_reg <= {mag_reg[DVD_W-2:0], fits};
        end
    end

    assign signed_quot = neg_reg ? (~mag_reg + 1'b1) : mag_reg;
    assign quotient    = $signed(signed_quot[QUOT_W-1:0]);
    assign done        = done_reg;

endmodule

/* rtl/wsd_win.sv */
// ----------------------------------------------------------------------------
// wsd_win
// ring of block averages with a one-entry-per-cycle min/max scan
// ----------------------------------------------------------------------------
module wsd_win #(
    parameter int DEPTH  = 5,
    parameter int DATA_W = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wsd_pkg::win_ctrl_t       ctrl,
    input  logic signed [DATA_W-1:0] wr_data,
    output logic                     scan_done,
    output logic signed [DATA_W-1:0] lo,
    output logic signed [DATA_W-1:0] hi
);

    import wsd_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic signed [DATA_W-1:0] win_mem [DEPTH];
    logic        [IDX_W-1:0]  slot_reg;
    logic        [IDX_W-1:0]  idx_reg;
    logic                     scanning_reg;
    logic                     done_reg;
    logic signed [DATA_W-1:0] lo_reg;
    logic signed [DATA_W-1:0] hi_reg;
    logic signed [DATA_W-1:0] rd_data;

    assign rd_data = win_mem[idx_reg];

    // ring storage, cleared on start
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                win_mem[i] <= '0;
            end
        end
        else if (ctrl.wr_en)
        begin
            win_mem[slot_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            idx_reg      <= '0;
            scanning_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.clear)
            begin
                slot_reg     <= '0;
                scanning_reg <= 1'b0;
            end
            else if (ctrl.wr_en)
            begin
                slot_reg     <= (slot_reg == LAST_IDX) ? '0 : slot_reg + 1'b1;
                idx_reg      <= '0;
                scanning_reg <= 1'b1;
            end
            else if (scanning_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    scanning_reg <= 1'b0;
                    done_reg     <= 1'b1;
                end
            end
        end
    end

    // shared min/max compare, first entry seeds both
    always_ff @(posedge clk)
    begin
        if (scanning_reg)
        begin
            if (idx_reg == '0)
            begin
                lo_reg <= rd_data;
                hi_reg <= rd_data;
            end
            else
            begin
                if (rd_data < lo_reg)
                begin
                    lo_reg <= rd_data;
                end
                if (rd_data > hi_reg)
                begin
                    hi_reg <= rd_data;
                end
            end
        end
    end

    assign scan_done = done_reg;
    assign lo        = lo_reg;
    assign hi        = hi_reg;

endmodule

/* rtl/weight_stability_detector.sv */
// ----------------------------------------------------------------------------
// weight_stability_detector
// settles a stream of load-cell samples into one stable weight per measurement
// ----------------------------------------------------------------------------
// A start beat (cmd = 1) clears the ring of WINDOW_DEPTH block averages to
// zero and begins a measurement; its sample is ignored. Each sample beat
// while measuring is added to a running sum; every samples_per_block samples
// (0 counts as 1) the sum is divided by the count, truncating toward zero,
// and the average is written into the ring. The ring's min and max, zero
// entries included, are then found; if max - min < max_spread the block
// returns floor((min + max) / 2) with status 0, otherwise after MAX_ATTEMPTS
// blocks it returns the latest average with status 1. Either result ends the
// measurement, and sample beats are ignored until the next start. A start
// beat or a sample that does not close a block is taken without a stall. A
// sample that closes a block is accepted, then the bit-serial divider forms
// the average, the average is written into the ring, the ring is scanned,
// and the sequencer sees the scan end and decides; in_stall is high after
// the accept until the decision, so the next beat waits for all of these
// steps. The result sits in an output register, so a new block may start
// while it waits to be taken; a later result waits for it, and in_stall
// stays high meanwhile.
// Configuration writes take effect at once and belong between beats.
// ----------------------------------------------------------------------------
module weight_stability_detector #(
    parameter int WINDOW_DEPTH = 5,
    parameter int MAX_ATTEMPTS = 30,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [wsd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [wsd_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic signed [SAMPLE_BITS-1:0]        sample_value,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_BITS-1:0]        weight_out,
    output logic                                 status,
    output logic [wsd_pkg::BLOCKS_W-1:0]         blocks_used
);

    import wsd_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + SPB_W;
    localparam int CMP_W = (SAMPLE_BITS + 2 > SPREAD_W + 1) ? SAMPLE_BITS + 2 : SPREAD_W + 1;
    localparam logic [BLOCKS_W-1:0] ATTEMPT_LIMIT = BLOCKS_W'(MAX_ATTEMPTS);

    // sequencer states
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE   = 2'd0;
    localparam logic [ST_W-1:0] ST_DIV    = 2'd1;
    localparam logic [ST_W-1:0] ST_SCAN   = 2'd2;
    localparam logic [ST_W-1:0] ST_DECIDE = 2'd3;

    // configuration registers
    logic [SPB_W-1:0]    spb_reg;
    logic [SPREAD_W-1:0] spread_lim_reg;

    // measurement state
    logic [ST_W-1:0]         state_reg,    state_next;
    logic                    measuring_reg, measuring_next;
    logic signed [SUM_W-1:0] sum_reg,      sum_next;
    logic [SPB_W-1:0]        count_reg,    count_next;
    logic [BLOCKS_W-1:0]     attempt_reg,  attempt_next;
    logic signed [SAMPLE_BITS-1:0] avg_reg, avg_next;

    // output register
    logic                          out_valid_reg,  out_valid_next;
    logic signed [SAMPLE_BITS-1:0] weight_reg,     weight_next;
    logic                          status_reg,     status_next;
    logic [BLOCKS_W-1:0]           blocks_reg,     blocks_next;

    // datapath
    logic                          in_beat;
    logic                          out_free;
    logic signed [SUM_W-1:0]       sum_add;
    logic [SPB_W-1:0]              count_inc;
    logic [SPB_W-1:0]              block_len;
    logic                          div_start;
    logic                          div_done;
    logic signed [SAMPLE_BITS-1:0] div_quot;
    win_ctrl_t                     win_ctrl;
    logic                          scan_done;
    logic signed [SAMPLE_BITS-1:0] win_lo;
    logic signed [SAMPLE_BITS-1:0] win_hi;
    logic signed [CMP_W-1:0]       spread;
    logic signed [CMP_W-1:0]       spread_lim;
    logic                          is_stable;
    logic                          is_timeout;
    logic signed [SAMPLE_BITS:0]   mid_sum;
    logic signed [SAMPLE_BITS:0]   mid_half;

    assign in_beat   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign sum_add   = sum_reg + SUM_W'(sample_value);
    assign count_inc = count_reg + 1'b1;
    assign block_len = (spb_reg == '0) ? SPB_W'(1) : spb_reg;

    // stability test and midpoint on the scanned extremes
    assign spread     = CMP_W'(win_hi) - CMP_W'(win_lo);
    assign spread_lim = $signed(CMP_W'(spread_lim_reg));
    assign is_stable  = (spread < spread_lim);
    assign is_timeout = (attempt_reg >= ATTEMPT_LIMIT);
    assign mid_sum    = (SAMPLE_BITS + 1)'(win_lo) + (SAMPLE_BITS + 1)'(win_hi);
    assign mid_half   = mid_sum >>> 1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg        <= SPB_RESET;
            spread_lim_reg <= SPREAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SAMPLES_PER_BLOCK: spb_reg        <= cfg_wr_data[SPB_W-1:0];
                REG_MAX_SPREAD:        spread_lim_reg <= cfg_wr_data[SPREAD_W-1:0];
                default:               ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        measuring_next = measuring_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        attempt_next   = attempt_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg && out_stall;
        weight_next    = weight_reg;
        status_next    = status_reg;
        blocks_next    = blocks_reg;
        div_start      = 1'b0;
        win_ctrl       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (cmd == CMD_START)
                    begin
                        win_ctrl.clear = 1'b1;
                        sum_next       = '0;
                        count_next     = '0;
                        attempt_next   = '0;
                        measuring_next = 1'b1;
                    end
                    else if (measuring_reg)
                    begin
                        if (count_inc >= block_len)
                        begin
                            // block closes: divide the full sum
                            div_start  = 1'b1;
                            sum_next   = '0;
                            count_next = '0;
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            sum_next   = sum_add;
                            count_next = count_inc;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    avg_next       = div_quot;
                    win_ctrl.wr_en = 1'b1;
                    attempt_next   = attempt_reg + 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (is_stable || is_timeout)
                begin
                    // hold until the output register can take the beat
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        weight_next    = is_stable ? mid_half[SAMPLE_BITS-1:0] : avg_reg;
                        status_next    = is_stable ? STATUS_STABLE : STATUS_TIMEOUT;
                        blocks_next    = attempt_reg;
                        measuring_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            measuring_reg <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            attempt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            measuring_reg <= measuring_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            attempt_reg   <= attempt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg    <= avg_next;
        weight_reg <= weight_next;
        status_reg <= status_next;
        blocks_reg <= blocks_next;
    end

    // bit-serial divider for the block average
    wsd_div #(
        .DVD_W  (SUM_W),
        .DVS_W  (SPB_W),
        .QUOT_W (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_add),
        .divisor  (block_len),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ring of block averages and min/max scan
    wsd_win #(
        .DEPTH  (WINDOW_DEPTH),
        .DATA_W (SAMPLE_BITS)
    ) u_win (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (win_ctrl),
        .wr_data   (div_quot),
        .scan_done (scan_done),
        .lo        (win_lo),
        .hi        (win_hi)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign weight_out  = weight_reg;
    assign status      = status_reg;
    assign blocks_used = blocks_reg;

    // divider finishes only while the sequencer waits for it
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    // scan finishes only while the sequencer waits for it
    a_scan_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done |-> state_reg == ST_SCAN)
        else $error("scan done outside scan state");

    // a new result ends the measurement
    a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> !measuring_reg && state_reg == ST_IDLE)
        else $error("result issued while still measuring");

    // blocks_used stays within the attempt limit
    a_blocks_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> blocks_reg != '0 && blocks_reg <= ATTEMPT_LIMIT)
        else $error("blocks_used out of range");

endmodule

/* test/weight_stability_detector_test.sv */
// ----------------------------------------------------------------------------
// weight_stability_detector_test
// self-checking bench for the weight stability detector
// ----------------------------------------------------------------------------
// A queue of pending beats feeds a clocked driver; a clocked monitor runs a
// cycle-free model of the detector on every accepted input beat and checks
// each accepted result against the oldest expected one. Stimulus opens with a
// short directed run (idle samples, restarts, rounding of the block average
// and of the midpoint, extreme samples), then random measurements under a set
// of register settings that includes the extremes: one sample per block, zero
// samples per block, the largest block, a zero and a full-scale spread. Both
// channels idle at random, one stretch runs with no idling, and once the
// receiver holds off long enough for the block to back up and stall input.
// ----------------------------------------------------------------------------
module weight_stability_detector_test;

    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam int RING_DEPTH = 5;
    localparam int MAX_TRIES = 30;
    localparam int WEIGHT_W = 24;
    localparam longint WEIGHT_MAX = 64'sd8388607;
    localparam longint WEIGHT_MIN = -64'sd8388608;
    localparam logic [SPREAD_W-1:0] SPREAD_MAX = '1;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 1350;

    // one input beat as queued for the driver
    typedef struct packed {
        logic                       op;
        logic signed [WEIGHT_W-1:0] val;
    } scale_beat_t;

    // one reading as the block reports it
    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic                       status;
        logic [BLOCKS_W-1:0]        blocks;
    } weight_result_t;

    // detector state plus its two registers
    typedef struct packed {
        logic [RING_DEPTH-1:0][WEIGHT_W-1:0] ring;
        logic [2:0]                          slot;
        logic signed [31:0]                  acc;
        logic [7:0]                          count;
        logic [BLOCKS_W-1:0]                 tries;
        logic                                busy;
        logic [SPB_W-1:0]                    spb;
        logic [SPREAD_W-1:0]                 spread;
    } det_state_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_wr_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        cmd = CMD_SAMPLE;
    logic signed [WEIGHT_W-1:0]  sample_value = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [WEIGHT_W-1:0]  weight_out;
    logic                        status;
    logic [BLOCKS_W-1:0]         blocks_used;

    logic                        start_hold = 1'b0;
    int                          hold_left = 0;
    int                          in_idle_pct = 14;
    int                          out_idle_pct = 14;

    scale_beat_t                 pending_beats[$];
    weight_result_t              expected_readings[$];
    det_state_t                  live_state;     // follows accepted beats
    det_state_t                  plan_state;     // follows queued beats
    int                          used_items = 0;
    int                          faults = 0;

    weight_stability_detector uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .weight_out   (weight_out),
        .status       (status),
        .blocks_used  (blocks_used)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // detector model
    // ------------------------------------------------------------------

    function automatic det_state_t reset_state();
        det_state_t s;
        s = '0;
        s.spb = SPB_RESET;
        s.spread = SPREAD_RESET;
        return s;
    endfunction

    // advances the state by one beat, returns 1 when a reading comes out
    function automatic bit settle_step(inout det_state_t st, input logic op,
                                       input logic signed [WEIGHT_W-1:0] val,
                                       output weight_result_t res);
        longint total;
        longint avg;
        longint lo;
        longint hi;
        longint entry;
        int     n;
        int     i;
        res = '0;
        // start clears the ring and arms; its sample is dropped
        if (op == CMD_START)
        begin
            st.ring = '0;
            st.slot = '0;
            st.acc = '0;
            st.count = '0;
            st.tries = '0;
            st.busy = 1'b1;
            return 1'b0;
        end
        // samples outside a measurement change nothing
        if (!st.busy)
            return 1'b0;
        total = longint'(st.acc) + longint'(val);
        st.count = st.count + 8'd1;
        // zero samples per block behaves as one
        n = (st.spb == '0) ? 1 : int'(st.spb);
        if (int'(st.count) < n)
        begin
            st.acc = 32'(total);
            return 1'b0;
        end
        // block average truncates toward zero
        avg = total / longint'(n);
        st.acc = '0;
        st.count = '0;
        if (st.slot >= 3'(RING_DEPTH))
            st.slot = '0;
        st.ring[st.slot] = 24'(avg);
        st.slot = (st.slot == 3'(RING_DEPTH - 1)) ? 3'd0 : st.slot + 3'd1;
        st.tries = st.tries + 5'd1;
        // extremes over the whole ring, untouched zero entries included
        lo = longint'($signed(st.ring[0]));
        hi = lo;
        for (i = 1; i < RING_DEPTH; i++)
        begin
            entry = longint'($signed(st.ring[i]));
            if (entry < lo)
                lo = entry;
            if (entry > hi)
                hi = entry;
        end
        if (hi - lo < longint'(st.spread))
        begin
            // midpoint rounds toward minus infinity
            res.weight = 24'((lo + hi) >>> 1);
            res.status = STATUS_STABLE;
            res.blocks = st.tries;
            st.busy = 1'b0;
            return 1'b1;
        end
        if (int'(st.tries) >= MAX_TRIES)
        begin
            // timeout reports the latest block average
            res.weight = 24'(avg);
            res.status = STATUS_TIMEOUT;
            res.blocks = st.tries;
            st.busy = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // input driver: next beat once the current one is taken
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        scale_beat_t next_beat;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_SAMPLE;
            sample_value <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= in_idle_pct)
            begin
                next_beat = pending_beats.pop_front();
                in_valid <= 1'b1;
                cmd <= next_beat.op;
                sample_value <= next_beat.val;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (start_hold)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // ------------------------------------------------------------------
    // monitor: predict on input beats, check output beats
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        weight_result_t fresh;
        weight_result_t got;
        weight_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (settle_step(live_state, cmd, sample_value, fresh))
                    expected_readings.push_back(fresh);
            end
            if (out_valid && !out_stall)
            begin
                got.weight = weight_out;
                got.status = status;
                got.blocks = blocks_used;
                if (expected_readings.size() == 0)
                begin
                    if (faults < 10)
                        $display("unexpected reading: weight %0d status %0d blocks %0d",
                                 got.weight, got.status, got.blocks);
                    faults++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.weight !== want.weight || got.status !== want.status
                        || got.blocks !== want.blocks)
                    begin
                        if (faults < 10)
                            $display({"reading mismatch: want weight %0d status %0d ",
                                      "blocks %0d, got weight %0d status %0d blocks %0d"},
                                     want.weight, want.status, want.blocks,
                                     got.weight, got.status, got.blocks);
                        faults++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // queue a beat and keep the planning copy in step
    task automatic push_item(input logic op, input logic signed [WEIGHT_W-1:0] val);
        weight_result_t dummy;
        if (op == CMD_START || plan_state.busy)
            used_items++;
        void'(settle_step(plan_state, op, val, dummy));
        pending_beats.push_back('{op: op, val: val});
    endtask

    function automatic logic signed [WEIGHT_W-1:0] near_weight(input longint base,
                                                                input longint jitter);
        longint v;
        v = base + longint'($urandom_range(32'(2 * jitter))) - jitter;
        if (v > WEIGHT_MAX)
            v = WEIGHT_MAX;
        if (v < WEIGHT_MIN)
            v = WEIGHT_MIN;
        return 24'(v);
    endfunction

    function automatic longint random_base();
        case ($urandom_range(7))
            0: return WEIGHT_MAX - longint'($urandom_range(500));
            1: return WEIGHT_MIN + longint'($urandom_range(500));
            2: return longint'($urandom_range(300)) - 150;
            default: return longint'($urandom_range(8000000)) - 4000000;
        endcase
    endfunction

    // start plus samples until a reading is planned, or cut short (-1: never)
    task automatic measure(input longint base, input longint jitter, input int cut);
        int k;
        k = 0;
        push_item(CMD_START, 24'($urandom()));
        while (plan_state.busy && k != cut)
        begin
            push_item(CMD_SAMPLE, near_weight(base, jitter));
            k++;
        end
    endtask

    // stray samples, dropped when no measurement is running
    task automatic stray_samples(input int n);
        repeat (n)
            push_item(CMD_SAMPLE, 24'($urandom()));
    endtask

    // wait for all beats taken, all readings back and the block quiet
    task automatic settle();
        while (pending_beats.size() != 0 || in_valid || expected_readings.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_SAMPLES_PER_BLOCK)
        begin
            live_state.spb = val[SPB_W-1:0];
            plan_state.spb = val[SPB_W-1:0];
        end
        else
        begin
            live_state.spread = val[SPREAD_W-1:0];
            plan_state.spread = val[SPREAD_W-1:0];
        end
    endtask

    task automatic set_regs(input logic [SPB_W-1:0] spb, input logic [SPREAD_W-1:0] spread);
        settle();
        write_reg(REG_SAMPLES_PER_BLOCK, CFG_DATA_W'(spb));
        write_reg(REG_MAX_SPREAD, CFG_DATA_W'(spread));
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial
    begin
        live_state = reset_state();
        plan_state = reset_state();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed: one sample per block, any spread below full scale is stable
        set_regs(8'd1, SPREAD_MAX);
        push_item(CMD_SAMPLE, 24'sh7FFFFF);      // idle, dropped
        push_item(CMD_START, 24'sh800000);       // start sample ignored
        push_item(CMD_SAMPLE, -24'sd3);          // midpoint of -3 and 0 floors to -2
        push_item(CMD_START, '0);
        push_item(CMD_SAMPLE, 24'sh7FFFFF);      // spread equals limit, not stable
        push_item(CMD_SAMPLE, 24'sh800000);
        push_item(CMD_START, 24'sh7FFFFF);       // restart mid-measurement
        push_item(CMD_SAMPLE, '0);

        // directed: two samples per block, tight spread
        set_regs(8'd2, 23'd5);
        push_item(CMD_START, '0);
        push_item(CMD_SAMPLE, -24'sd3);          // average -5/2 truncates to -2
        push_item(CMD_SAMPLE, -24'sd2);
        push_item(CMD_START, '0);
        repeat (5)
        begin
            push_item(CMD_SAMPLE, 24'sd7);       // stable only once the zeros are gone
            push_item(CMD_SAMPLE, 24'sd8);
        end

        // reset values, written back explicitly
        set_regs(SPB_RESET, SPREAD_RESET);
        repeat (5)
        begin
            measure(random_base(), 60, -1);
            stray_samples($urandom_range(2));
        end

        // single-sample blocks behind a long receiver hold-off
        set_regs(8'd1, SPREAD_MAX);
        @(posedge clk);
        start_hold <= 1'b1;
        @(posedge clk);
        start_hold <= 1'b0;
        repeat (60)
            measure(0, 64'sd8388608, -1);

        // zero samples per block, zero spread: every measurement that runs to the end times out
        set_regs('0, '0);
        measure(random_base(), 3000, 7);
        repeat (5)
            measure(random_base(), 3000, -1);

        // largest block with full-range samples
        set_regs(8'd255, SPREAD_MAX);
        measure(0, 64'sd8388608, 600);

        // no idling on either side
        set_regs(8'd2, 23'd1000);
        in_idle_pct = 0;
        out_idle_pct = 0;
        repeat (6)
            measure(random_base(), 1500, -1);
        settle();
        in_idle_pct = 14;
        out_idle_pct = 14;

        // random settings until enough beats have done work
        while (used_items < ITEM_TARGET)
        begin
            set_regs(8'($urandom_range(1, 6)),
                     ($urandom_range(3) == 0) ? 23'($urandom()) : 23'($urandom_range(400)));
            repeat (4)
            begin
                measure(random_base(), longint'($urandom_range(300)),
                        ($urandom_range(4) == 0) ? int'($urandom_range(1, 8)) : -1);
                stray_samples($urandom_range(2));
            end
        end

        settle();
        if (faults == 0 && expected_readings.size() == 0)
            $display("[weight_stability_detector] OK");
        else
            $display("[weight_stability_detector] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("[weight_stability_detector] ERROR");
        $finish;
    end

endmodule
